// ===== hw/rtl/gca_pkg.sv =====
// Shared constants, types and build-time gamma tables for the gamma-correct ARGB blender.
package gca_pkg;

    localparam int GAMMA_X100    = 220;
    localparam int LINEAR_BITS   = 16;
    localparam int PROGRESS_BITS = 16;

    localparam int CH_W         = 8;
    localparam int COLOR_W      = 32;
    localparam int PROG_IN_W    = 17;
    localparam int LIN_W        = LINEAR_BITS + 1;
    localparam int P_W          = PROGRESS_BITS + 1;
    localparam int PC_W         = (P_W > PROG_IN_W) ? P_W : PROG_IN_W;
    localparam int N_CODES      = 256;
    localparam int N_MIDS       = 255;
    localparam int SEARCH_STEPS = 8;
    localparam int SRCH_STG0    = 3;
    localparam int N_STAGES     = SRCH_STG0 + SEARCH_STEPS + 1;
    localparam int HALF_P       = 1 << (PROGRESS_BITS - 1);
    localparam int CP_W         = LIN_W + P_W + 2;
    localparam int AP_W         = CH_W + P_W + 2;

    typedef logic [CH_W-1:0]                 t_code;
    typedef logic [LIN_W-1:0]                t_lin;
    typedef logic [P_W-1:0]                  t_prog;
    typedef logic [N_CODES-1:0][LIN_W-1:0]   t_dec_tab;
    typedef logic [N_MIDS-1:0][LIN_W-1:0]    t_mid_tab;
    typedef logic [32:0][63:0]               t_root_tab;

    typedef struct packed {
        logic [N_STAGES-1:0] adv;
    } t_pipe_ctl;

    localparam t_prog               PROG_FULL = P_W'(1) << PROGRESS_BITS;
    localparam logic [N_STAGES-1:0] STG_ONES  = '1;

    function automatic logic [63:0] isqrt_u64(input logic [63:0] xi);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bv;
        int          j;
        x   = xi;
        res = '0;
        bv  = 64'd1 << 62;
        for (j = 0; j < 32; j++) begin
            if (bv > x) begin
                bv = bv >> 2;
            end
        end
        for (j = 0; j < 32; j++) begin
            if (bv != 64'd0) begin
                if (x >= res + bv) begin
                    x   = x - (res + bv);
                    res = (res >> 1) + bv;
                end else begin
                    res = res >> 1;
                end
                bv = bv >> 2;
            end
        end
        return res;
    endfunction

    function automatic t_root_tab build_roots();
        t_root_tab rt;
        int        i;
        rt[0] = 64'd1 << 31;
        for (i = 1; i <= 32; i++) begin
            rt[i] = isqrt_u64(rt[i-1] << 32);
        end
        return rt;
    endfunction

    function automatic logic [63:0] log2_q32(input logic [31:0] n);
        logic [63:0] m;
        logic [63:0] frac;
        int          k;
        int          j;
        k = 0;
        for (j = 0; j < 31; j++) begin
            if ((n >> (j + 1)) != 32'd0) begin
                k = j + 1;
            end
        end
        m    = ({32'd0, n} << 30) >> k;
        frac = '0;
        for (j = 0; j < 32; j++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m       = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(k) << 32) | frac;
    endfunction

    // round((n/d)^gamma) in LINEAR_BITS fraction bits
    function automatic t_lin gamma_pow(input logic [31:0] n, input logic [31:0] d,
                                       input t_root_tab rt);
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] acc;
        logic [63:0] v;
        int          i;
        if (n == 32'd0) begin
            return '0;
        end
        t   = log2_q32(d) - log2_q32(n);
        s   = (t * 64'(GAMMA_X100)) / 64'd100;
        acc = 64'd1 << 32;
        for (i = 1; i <= 32; i++) begin
            if (s[32-i]) begin
                acc = (acc * rt[i]) >> 32;
            end
        end
        if (s[63:32] >= 32'd40) begin
            return '0;
        end
        v = acc >> s[63:32];
        return t_lin'((v + (64'd1 << (31 - LINEAR_BITS))) >> (32 - LINEAR_BITS));
    endfunction

    function automatic t_dec_tab build_dec_tab();
        t_dec_tab  tab;
        t_root_tab rt;
        int        c;
        rt = build_roots();
        for (c = 0; c < N_CODES; c++) begin
            tab[c] = gamma_pow(32'(c), 32'd255, rt);
        end
        return tab;
    endfunction

    function automatic t_mid_tab build_mid_tab();
        t_mid_tab  tab;
        t_root_tab rt;
        int        c;
        rt = build_roots();
        for (c = 0; c < N_MIDS; c++) begin
            tab[c] = gamma_pow(32'(2 * c + 1), 32'd510, rt);
        end
        return tab;
    endfunction

    localparam t_dec_tab DEC_TAB = build_dec_tab();
    localparam t_mid_tab MID_TAB = build_mid_tab();

    function automatic t_prog clamp_prog(input logic [PROG_IN_W-1:0] p);
        logic [PC_W-1:0] pe;
        pe = PC_W'(p);
        if (pe > PC_W'(PROG_FULL)) begin
            return PROG_FULL;
        end
        return P_W'(pe);
    endfunction

endpackage

// ===== hw/rtl/gca_if.sv =====
// Valid/ready channel interfaces for the blender's input pairs and output colors.
interface gca_in_if import gca_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [COLOR_W-1:0]   start_color;
    logic [COLOR_W-1:0]   end_color;
    logic [PROG_IN_W-1:0] progress;

    modport source (output valid, output start_color, output end_color, output progress,
                    input ready);
    modport sink (input valid, input start_color, input end_color, input progress,
                  output ready);
endinterface

interface gca_out_if import gca_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] blended_color;

    modport source (output valid, output blended_color, input ready);
    modport sink (input valid, input blended_color, output ready);
endinterface

// ===== hw/rtl/gca_alpha_lane.sv =====
// Alpha lane: linear blend of 8-bit alpha codes, delayed to match the color lanes.
module gca_alpha_lane import gca_pkg::*; (
    input  logic                 i_clk,
    input  t_pipe_ctl            i_ctl,
    input  t_code                i_start_code,
    input  t_code                i_end_code,
    input  logic [PROG_IN_W-1:0] i_progress,
    output t_code                o_code
);

    t_code                  r_a0;
    t_code                  r_b0;
    t_prog                  r_p0;
    t_code                  r_a1;
    logic signed [AP_W-1:0] r_prod;
    t_code                  r_y;
    t_code                  r_dly [SEARCH_STEPS];

    logic signed [CH_W:0]   n_diff;
    logic signed [AP_W-1:0] n_prod;
    logic signed [AP_W-1:0] n_sum;

    always_comb begin
        n_diff = $signed({1'b0, r_b0}) - $signed({1'b0, r_a0});
        n_prod = n_diff * $signed({1'b0, r_p0});
        n_sum  = $signed({3'b000, r_a1, {PROGRESS_BITS{1'b0}}}) + r_prod
                 + $signed(AP_W'(HALF_P));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r_a0 <= i_start_code;
            r_b0 <= i_end_code;
            r_p0 <= clamp_prog(i_progress);
        end
        if (i_ctl.adv[1]) begin
            r_a1   <= r_a0;
            r_prod <= n_prod;
        end
        if (i_ctl.adv[2]) begin
            r_y <= n_sum[PROGRESS_BITS +: CH_W];
        end
        if (i_ctl.adv[SRCH_STG0]) begin
            r_dly[0] <= r_y;
        end
        for (int j = 1; j < SEARCH_STEPS; j++) begin
            if (i_ctl.adv[SRCH_STG0 + j]) begin
                r_dly[j] <= r_dly[j-1];
            end
        end
    end

    assign o_code = r_dly[SEARCH_STEPS-1];

endmodule

// ===== hw/rtl/gca_color_lane.sv =====
// Color lane: gamma decode, linear-light blend and pipelined binary-search re-encode.
module gca_color_lane import gca_pkg::*; (
    input  logic                 i_clk,
    input  t_pipe_ctl            i_ctl,
    input  t_code                i_start_code,
    input  t_code                i_end_code,
    input  logic [PROG_IN_W-1:0] i_progress,
    output t_code                o_code
);

    t_lin                   r_a0;
    t_lin                   r_b0;
    t_prog                  r_p0;
    t_lin                   r_a1;
    logic signed [CP_W-1:0] r_prod;
    t_lin                   r_x;
    t_code                  r_lo [SEARCH_STEPS];
    t_lin                   r_xs [SEARCH_STEPS-1];

    logic signed [LIN_W:0]  n_diff;
    logic signed [CP_W-1:0] n_prod;
    logic signed [CP_W-1:0] n_sum;
    t_code                  w_lo_in [SEARCH_STEPS];
    t_lin                   w_x_in  [SEARCH_STEPS];
    t_code                  w_cand  [SEARCH_STEPS];
    t_code                  w_idx   [SEARCH_STEPS];
    t_code                  n_lo    [SEARCH_STEPS];

    always_comb begin
        n_diff = $signed({1'b0, r_b0}) - $signed({1'b0, r_a0});
        n_prod = n_diff * $signed({1'b0, r_p0});
        n_sum  = $signed({3'b000, r_a1, {PROGRESS_BITS{1'b0}}}) + r_prod
                 + $signed(CP_W'(HALF_P));
    end

    // one search step per stage; ties on a threshold go to the higher code
    always_comb begin
        for (int j = 0; j < SEARCH_STEPS; j++) begin
            if (j == 0) begin
                w_lo_in[j] = '0;
                w_x_in[j]  = r_x;
            end else begin
                w_lo_in[j] = r_lo[j-1];
                w_x_in[j]  = r_xs[j-1];
            end
            w_cand[j] = w_lo_in[j] | t_code'(1 << (SEARCH_STEPS - 1 - j));
            w_idx[j]  = w_cand[j] - t_code'(1);
            n_lo[j]   = (MID_TAB[w_idx[j]] <= w_x_in[j]) ? w_cand[j] : w_lo_in[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r_a0 <= DEC_TAB[i_start_code];
            r_b0 <= DEC_TAB[i_end_code];
            r_p0 <= clamp_prog(i_progress);
        end
        if (i_ctl.adv[1]) begin
            r_a1   <= r_a0;
            r_prod <= n_prod;
        end
        if (i_ctl.adv[2]) begin
            r_x <= n_sum[PROGRESS_BITS +: LIN_W];
        end
        for (int j = 0; j < SEARCH_STEPS; j++) begin
            if (i_ctl.adv[SRCH_STG0 + j]) begin
                r_lo[j] <= n_lo[j];
            end
        end
        for (int j = 0; j < SEARCH_STEPS - 1; j++) begin
            if (i_ctl.adv[SRCH_STG0 + j]) begin
                r_xs[j] <= w_x_in[j];
            end
        end
    end

    assign o_code = r_lo[SEARCH_STEPS-1];

endmodule

// ===== hw/rtl/gamma_correct_argb_lerp.sv =====
// Top level of the gamma-correct ARGB8888 blender: lanes, pipeline control and merge register.
// Takes one color pair per clock and gives one blended color per clock while the output
// is not stalled. Four lanes run side by side: alpha is blended linearly on its codes, while
// red, green and blue are decoded to linear light by table, blended with one multiplier
// stage, and re-encoded by an eight-stage binary search over midpoint thresholds, one stage
// per result bit; a merge register packs the four codes. The pipeline runs decode, multiply,
// sum, search and merge stages in order. Stages advance independently, so empty stages
// close up behind a stalled output, and input is refused only when all twelve stages hold data.
module gamma_correct_argb_lerp import gca_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    gca_in_if.sink      i_pix,
    gca_out_if.source   o_pix
);

    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] n_vld;
    logic [COLOR_W-1:0]  r_color;
    logic [COLOR_W-1:0]  n_color;
    t_pipe_ctl           w_ctl;
    t_code               w_alpha;
    t_code               w_chan [3];

    // a stage advances unless it and every stage after it are full and the output stalls
    always_comb begin
        for (int k = 0; k < N_STAGES; k++) begin
            w_ctl.adv[k] = o_pix.ready || ((r_vld >> k) != (STG_ONES >> k));
        end
        n_vld = {r_vld[N_STAGES-2:0], i_pix.valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < N_STAGES; k++) begin
                if (w_ctl.adv[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    gca_alpha_lane u_alpha (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_start_code (i_pix.start_color[COLOR_W-1 -: CH_W]),
        .i_end_code   (i_pix.end_color[COLOR_W-1 -: CH_W]),
        .i_progress   (i_pix.progress),
        .o_code       (w_alpha)
    );

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        gca_color_lane u_color (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_start_code (i_pix.start_color[(2 - ch) * CH_W +: CH_W]),
            .i_end_code   (i_pix.end_color[(2 - ch) * CH_W +: CH_W]),
            .i_progress   (i_pix.progress),
            .o_code       (w_chan[ch])
        );
    end

    assign n_color = {w_alpha, w_chan[0], w_chan[1], w_chan[2]};

    always_ff @(posedge i_clk) begin
        if (w_ctl.adv[N_STAGES-1]) begin
            r_color <= n_color;
        end
    end

    assign i_pix.ready         = w_ctl.adv[0];
    assign o_pix.valid         = r_vld[N_STAGES-1];
    assign o_pix.blended_color = r_color;

    a_in_loads_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_vld[0])
        else $error("accepted transfer did not enter the first stage");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !o_pix.ready |-> !i_pix.ready)
        else $error("input taken while the pipeline is full and stalled");

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(|r_vld) |-> i_pix.ready)
        else $error("empty pipeline refused input");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) && !(o_pix.valid && o_pix.ready)
        |=> $countones(r_vld) == $past($countones(r_vld)) + 1)
        else $error("occupancy did not grow by one");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pix.valid && i_pix.ready) && (o_pix.valid && o_pix.ready)
        |=> $countones(r_vld) + 1 == $past($countones(r_vld)))
        else $error("occupancy did not shrink by one");

endmodule
